@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use samples on the rising edge of clk
// and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold on every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/ebb_pkg.sv @@
package ebb_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int COL_SUM_W   = 10;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 15;
    localparam int PROD_W      = RECIP_SHIFT + PIX_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCOUNT_W    = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // Work for the back end: up to two results from one input item.
    // Result A is the pixel one column behind; result B closes a row.
    typedef struct packed {
        logic             a_valid;
        logic [SUM_W-1:0] a_sum;
        logic [1:0]       a_cols;
        logic             b_valid;
        logic [SUM_W-1:0] b_sum;
        logic [1:0]       b_cols;
        logic [1:0]       rows;
        logic             done;
    } job_t;

    // Reciprocal of the neighbor count, scaled by 2**RECIP_SHIFT and rounded up.
    // The rounding error stays small enough that the truncated quotient is exact
    // for every sum a 3x3 window of 8-bit pixels can reach.
    function automatic logic [RECIP_W-1:0] ebb_recip(input logic [1:0] cols,
                                                     input logic [1:0] rows);
        logic [3:0] n;
        n = 4'(cols) * 4'(rows);
        unique case (n)
            4'd2:    return 16'd16384;
            4'd3:    return 16'd10923;
            4'd4:    return 16'd8192;
            4'd6:    return 16'd5462;
            4'd9:    return 16'd3641;
            default: return 16'd32768;
        endcase
    endfunction

endpackage

@@ src/ebb_front.sv @@
module ebb_front
    import ebb_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIX_W-1:0]       pixel_value,
    input  logic                   fill,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [QCOUNT_W-1:0]    q_count,
    output logic                   push,
    output job_t                   push_job
);

    localparam int XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int W_RST = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;
    localparam int H_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

    logic [CW-1:0] w_reg, w_next;
    logic [RW-1:0] h_reg, h_next;
    logic [XW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [PIX_W-1:0] store0 [MAX_COLUMNS];
    logic [PIX_W-1:0] store1 [MAX_COLUMNS];
    logic [PIX_W-1:0] rd0_reg, rd1_reg;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_par_reg, s1_tv_reg, s1_bv_reg, s1_row_nz_reg;
    logic             s1_ge1_reg, s1_ge2_reg, s1_row_end_reg, s1_virt_reg;

    logic [COL_SUM_W-1:0] cs_l_reg, cs_m_reg;

    logic             accept;
    logic             cfg_hit;
    logic             virt;
    logic             row_end;
    logic [PIX_W-1:0] pix_eff;
    logic [QCOUNT_W:0] occupancy;

    logic [PIX_W-1:0]     older, newer;
    logic [COL_SUM_W-1:0] cs_cur;

    assign occupancy = {1'b0, q_count} + {{QCOUNT_W{1'b0}}, s1_valid_reg};
    // A job from the item in flight plus one from a new item must both fit.
    assign in_stall  = (occupancy >= (QCOUNT_W + 1)'(QUEUE_DEPTH));
    assign accept    = in_valid && !in_stall;

    assign virt    = (row_reg == h_reg);
    assign row_end = ((CW'(col_reg) + CW'(1)) == w_reg);
    assign pix_eff = (fill || virt) ? '0 : pixel_value;
    assign cfg_hit = cfg_valid && ((cfg_index == REG_FRAME_WIDTH) ||
                                   (cfg_index == REG_FRAME_HEIGHT));

    always_comb
    begin
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_valid && (cfg_index == REG_FRAME_WIDTH))
        begin
            if (cfg_data == '0)
                w_next = CW'(1);
            else if (32'(cfg_data) > MAX_COLUMNS)
                w_next = CW'(MAX_COLUMNS);
            else
                w_next = CW'(cfg_data);
        end
        if (cfg_valid && (cfg_index == REG_FRAME_HEIGHT))
        begin
            if (cfg_data == '0)
                h_next = RW'(1);
            else if (32'(cfg_data) > MAX_ROWS)
                h_next = RW'(MAX_ROWS);
            else
                h_next = RW'(cfg_data);
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = virt ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= CW'(W_RST);
            h_reg        <= RW'(H_RST);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            cs_l_reg     <= '0;
            cs_m_reg     <= '0;
        end
        else
        begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                cs_l_reg <= cs_m_reg;
                cs_m_reg <= cs_cur;
            end
        end
    end

    // The row stores alternate by row parity: the store of the current parity
    // holds the row two above, which is read out before this row overwrites it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd0_reg <= store0[col_reg];
            if (!row_reg[0])
                store0[col_reg] <= pix_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd1_reg <= store1[col_reg];
            if (row_reg[0])
                store1[col_reg] <= pix_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= pix_eff;
            s1_par_reg     <= row_reg[0];
            s1_tv_reg      <= (row_reg > RW'(1));
            s1_bv_reg      <= !virt;
            s1_row_nz_reg  <= (row_reg != '0);
            s1_ge1_reg     <= (col_reg != '0);
            s1_ge2_reg     <= (col_reg > XW'(1));
            s1_row_end_reg <= row_end;
            s1_virt_reg    <= virt;
        end
    end

    assign older  = s1_par_reg ? rd1_reg : rd0_reg;
    assign newer  = s1_par_reg ? rd0_reg : rd1_reg;
    assign cs_cur = (s1_tv_reg ? COL_SUM_W'(older) : '0) + COL_SUM_W'(newer)
                  + (s1_bv_reg ? COL_SUM_W'(s1_pix_reg) : '0);

    always_comb
    begin
        push_job.a_valid = s1_row_nz_reg && s1_ge1_reg;
        push_job.a_sum   = (s1_ge2_reg ? SUM_W'(cs_l_reg) : '0) + SUM_W'(cs_m_reg)
                         + SUM_W'(cs_cur);
        push_job.a_cols  = s1_ge2_reg ? 2'd3 : 2'd2;
        push_job.b_valid = s1_row_nz_reg && s1_row_end_reg;
        push_job.b_sum   = (s1_ge1_reg ? SUM_W'(cs_m_reg) : '0) + SUM_W'(cs_cur);
        push_job.b_cols  = s1_ge1_reg ? 2'd2 : 2'd1;
        push_job.rows    = 2'd1 + {1'b0, s1_tv_reg} + {1'b0, s1_bv_reg};
        push_job.done    = s1_virt_reg;
    end

    assign push = s1_valid_reg && (push_job.a_valid || push_job.b_valid);

endmodule

@@ src/ebb_queue.sv @@
module ebb_queue
    import ebb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  job_t                push_job,
    input  logic                pop,
    output job_t                head,
    output logic                empty,
    output logic [QCOUNT_W-1:0] count
);

    job_t                slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCOUNT_W'(push) - QCOUNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    assign head  = slots_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

@@ src/ebb_back.sv @@
module ebb_back
    import ebb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  job_t             head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] blurred_value,
    output logic             last_of_run,
    output logic             frame_done
);

    logic              phase_reg, phase_next;
    logic              m_valid_reg;
    logic [PROD_W-1:0] m_prod_reg;
    logic              m_last_reg, m_done_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_value_reg;
    logic              out_last_reg, out_done_reg;

    logic                     o_free, m_adv, issue, sel_b;
    logic [SUM_W-1:0]         sum;
    logic [1:0]               cols;
    logic [RECIP_W-1:0]       recip;
    logic [SUM_W+RECIP_W-1:0] product;

    assign o_free = !out_valid_reg || !out_stall;
    assign m_adv  = !m_valid_reg || o_free;
    assign issue  = !empty && m_adv;

    // Phase one means result A of the head job has gone and result B remains.
    assign sel_b   = phase_reg || !head.a_valid;
    assign sum     = sel_b ? head.b_sum : head.a_sum;
    assign cols    = sel_b ? head.b_cols : head.a_cols;
    assign recip   = ebb_recip(cols, head.rows);
    assign product = (SUM_W + RECIP_W)'(sum) * (SUM_W + RECIP_W)'(recip);
    assign pop     = issue && (sel_b || !head.b_valid);

    always_comb
    begin
        phase_next = phase_reg;
        if (issue)
            phase_next = !sel_b && head.b_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (m_adv)
                m_valid_reg <= issue;
            if (o_free)
                out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            m_prod_reg <= product[PROD_W-1:0];
            m_last_reg <= sel_b || !head.b_valid;
            m_done_reg <= sel_b && head.done;
        end
        if (o_free && m_valid_reg)
        begin
            out_value_reg <= m_prod_reg[RECIP_SHIFT +: PIX_W];
            out_last_reg  <= m_last_reg;
            out_done_reg  <= m_done_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign blurred_value = out_value_reg;
    assign last_of_run   = out_last_reg;
    assign frame_done    = out_done_reg;

endmodule

@@ src/edge_clipped_box_blur_3x3.sv @@
// The first result of an item passes the front stage register, the job queue, the product
// register and the output register; a second result of an item that ends a row follows it.
// Throughput: one item per cycle while in_stall is low; an item that ends a row can give two
// results, and the four-job queue absorbs the extra result.
// Reset: positions return to the frame origin and width and height to 1024 (or the
// maximum); the row stores are not cleared, their stale entries are always masked.
`include "assert_macros.svh"

module edge_clipped_box_blur_3x3
    import ebb_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIX_W-1:0]       pixel_value,
    input  logic                   fill,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIX_W-1:0]       blurred_value,
    output logic                   last_of_run,
    output logic                   frame_done,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                push, pop, q_empty;
    job_t                push_job, head;
    logic [QCOUNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    ebb_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .fill        (fill),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_count     (q_count),
        .push        (push),
        .push_job    (push_job)
    );

    ebb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .count    (q_count)
    );

    ebb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blurred_value (blurred_value),
        .last_of_run   (last_of_run),
        .frame_done    (frame_done)
    );

    `ASSERT_ALWAYS(a_queue_bound, (32'(q_count) <= QUEUE_DEPTH), "queue count above depth")
    `ASSERT_IMPLIES(a_no_overflow, push, ((32'(q_count) < QUEUE_DEPTH) || pop), "overflow")
    `ASSERT_IMPLIES(a_no_underflow, pop, !q_empty, "pop from empty queue")
    `ASSERT_IMPLIES(a_done_is_last, out_valid && frame_done, last_of_run, "done not last")

endmodule

@@ test/edge_clipped_box_blur_3x3_test.sv @@
`timescale 1ns / 100ps

module edge_clipped_box_blur_3x3_test;
    import ebb_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int COLUMN_LIMIT    = 1024;
    localparam int ROW_LIMIT       = 1024;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_ITEMS    = 400;
    localparam int PARTIAL_ITEMS   = 44;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
        logic             done;
    } blur_result_t;

    // Index 0 is the top row, 2 the bottom row of one window column.
    typedef logic [2:0][PIX_W-1:0] pixel_column_t;

    class blur_scoreboard;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        logic [PIX_W-1:0]      older_row [COLUMN_LIMIT];
        logic [PIX_W-1:0]      newer_row [COLUMN_LIMIT];
        pixel_column_t         two_back;
        pixel_column_t         one_back;
        int unsigned           col_pos;
        int unsigned           row_pos;
        blur_result_t          expected_pixels [$];
        int                    errors;

        function new();
            width_reg  = CFG_DATA_W'(COLUMN_LIMIT);
            height_reg = CFG_DATA_W'(ROW_LIMIT);
            two_back   = '0;
            one_back   = '0;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
        endfunction

        function int unsigned clamp_size(logic [CFG_DATA_W-1:0] raw, int unsigned limit);
            if (raw == 0)
                return 1;
            if (raw > limit)
                return limit;
            return 32'(raw);
        endfunction

        function int unsigned columns();
            return clamp_size(width_reg, COLUMN_LIMIT);
        endfunction

        function int unsigned rows();
            return clamp_size(height_reg, ROW_LIMIT);
        endfunction

        // A frame is its real rows plus one row of fill items.
        function int unsigned frame_items();
            return (rows() + 1) * columns();
        endfunction

        function int unsigned items_to_frame_end();
            return frame_items() - (row_pos * columns() + col_pos);
        endfunction

        function bit in_fill_row();
            return row_pos >= rows();
        endfunction

        function bit idle();
            return expected_pixels.size() == 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_FRAME_WIDTH)
                width_reg = data;
            else if (index == REG_FRAME_HEIGHT)
                height_reg = data;
            else
                return;
            col_pos = 0;
            row_pos = 0;
        endfunction

        function int unsigned column_total(pixel_column_t col, logic tv, logic bv);
            int unsigned total;
            total = 32'(col[1]);
            if (tv)
                total += 32'(col[0]);
            if (bv)
                total += 32'(col[2]);
            return total;
        endfunction

        function logic [PIX_W-1:0] box_mean(pixel_column_t left, pixel_column_t centre,
                                            pixel_column_t right, logic lv, logic rv,
                                            logic tv, logic bv);
            int unsigned total;
            int unsigned count;
            total = column_total(centre, tv, bv);
            count = 1;
            if (lv)
            begin
                total += column_total(left, tv, bv);
                count++;
            end
            if (rv)
            begin
                total += column_total(right, tv, bv);
                count++;
            end
            count = count * (1 + int'(tv) + int'(bv));
            return PIX_W'(total / count);
        endfunction

        function void note_input(logic [PIX_W-1:0] value, logic is_fill);
            int unsigned  w;
            int unsigned  h;
            int unsigned  c;
            int unsigned  r;
            logic [PIX_W-1:0] pix;
            pixel_column_t here;
            logic         tv;
            logic         bv;
            logic         row_end;
            blur_result_t res;
            w = columns();
            h = rows();
            c = col_pos;
            r = row_pos;
            // Fill inside a real row counts as a black pixel; anything in the
            // fill row carries no pixel at all.
            pix = (is_fill || r >= h) ? '0 : value;
            here[0] = older_row[c];
            here[1] = newer_row[c];
            here[2] = pix;
            older_row[c] = here[1];
            newer_row[c] = pix;
            tv      = (r >= 2);
            bv      = (r < h);
            row_end = (c + 1 >= w);
            if (r >= 1)
            begin
                if (c >= 1)
                begin
                    res.value = box_mean(two_back, one_back, here, c >= 2, 1'b1, tv, bv);
                    res.last  = !row_end;
                    res.done  = 1'b0;
                    expected_pixels.push_back(res);
                end
                if (row_end)
                begin
                    res.value = box_mean(one_back, here, here, c >= 1, 1'b0, tv, bv);
                    res.last  = 1'b1;
                    res.done  = (r >= h);
                    expected_pixels.push_back(res);
                end
            end
            two_back = one_back;
            one_back = here;
            if (row_end)
            begin
                col_pos = 0;
                row_pos = (r >= h) ? 0 : r + 1;
            end
            else
                col_pos = c + 1;
        endfunction

        task report(string what);
            $display("ERROR at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [PIX_W-1:0] value, logic last, logic done);
            blur_result_t want;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("blurred_value %0d arrived with nothing expected", value));
                return;
            end
            want = expected_pixels.pop_front();
            if (value !== want.value)
                report($sformatf("blurred_value %0d, expected %0d", value, want.value));
            if (last !== want.last)
                report($sformatf("last_of_run %0b, expected %0b", last, want.last));
            if (done !== want.done)
                report($sformatf("frame_done %0b, expected %0b", done, want.done));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PIX_W-1:0]       pixel_value = '0;
    logic                   fill = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PIX_W-1:0]       blurred_value;
    logic                   last_of_run;
    logic                   frame_done;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    blur_scoreboard board = new();
    bit calm = 1'b0;
    bit hold_off_request = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    edge_clipped_box_blur_3x3 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_value   (pixel_value),
        .fill          (fill),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blurred_value (blurred_value),
        .last_of_run   (last_of_run),
        .frame_done    (frame_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll < 3)
            return CFG_DATA_W'($urandom_range(9, 24));
        return CFG_DATA_W'($urandom_range(1, 8));
    endfunction

    // All driving tasks are entered and left at a falling edge.
    task automatic send_item(input logic [PIX_W-1:0] value, input logic is_fill);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= value;
        fill        <= is_fill;
        do @(posedge clk); while (in_stall);
        board.note_input(value, is_fill);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_stream(input int unsigned count);
        repeat (count)
        begin
            if (board.in_fill_row())
                send_item(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 9) != 0);
            else
                send_item(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end
    endtask

    // Items with no result may still be inside the block when the last
    // expected pixel has come out, hence the settle time.
    task automatic drain();
        in_valid <= 1'b0;
        while (!board.idle())
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    initial
    begin : result_side
        int gap;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(blurred_value, last_of_run, frame_done);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int goal;
        int choice;
        int unsigned count;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The reset frame is 1024 wide, so a short first row gives nothing.
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        drain();

        // 3x3 frame: corners, edges and centre, both pixel extremes, a fill
        // inside a real row and a pixel inside the fill row.
        configure(11'd3, 11'd3);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd99, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd77, 1'b0);
        send_item(8'd0, 1'b1);
        drain();

        // Zero width and height behave as one.
        configure(11'd0, 11'd0);
        send_item(8'd200, 1'b0);
        send_item(8'd0, 1'b1);
        drain();

        // A write to a spare index leaves the frame where it is; a real
        // write restarts it.
        configure(11'd2, 11'd2);
        send_item(8'd10, 1'b0);
        send_item(8'd250, 1'b0);
        send_item(8'd3, 1'b0);
        drain();
        write_register(REG_SPARE_3, '1);
        send_item(8'd40, 1'b0);
        drain();
        write_register(REG_FRAME_WIDTH, 11'd2);
        send_stream(board.items_to_frame_end());
        drain();

        // Oversized registers saturate to the largest frame; only the start
        // of each such frame is sent.
        configure(11'd2047, 11'd1);
        send_stream(PARTIAL_ITEMS);
        drain();
        configure(11'd1, 11'd2047);
        send_stream(PARTIAL_ITEMS);
        drain();

        // Long output hold while the source keeps offering pixels.
        configure(11'd12, 11'd8);
        hold_off_request = 1'b1;
        send_stream(board.items_to_frame_end());
        drain();

        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            calm = ($urandom_range(0, 4) == 0);
            choice = $urandom_range(0, 9);
            if (choice < 6)
                configure(pick_dim(), pick_dim());
            else if (choice == 6)
                write_register(REG_FRAME_WIDTH, pick_dim());
            else if (choice == 7)
                write_register(REG_FRAME_HEIGHT, pick_dim());
            else if (choice == 8)
                write_register(REG_SPARE_2, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 7) == 0)
                count = $urandom_range(1, board.items_to_frame_end());
            else
            begin
                count = board.items_to_frame_end();
                if ($urandom_range(0, 3) == 0)
                    count += board.frame_items();
            end
            if (count > 32'(goal - items_sent))
                count = 32'(goal - items_sent);
            send_stream(count);
            drain();
        end

        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
